[hw/rtl/obtob_pkg.sv]
`timescale 1ns / 1ps
package obtob_pkg;

  localparam int unsigned PRICE_W = 32;
  localparam int unsigned QTY_W   = 48;

  typedef enum logic [2:0] {
    OP_LEVEL     = 3'd0,
    OP_SNAP_BEG  = 3'd1,
    OP_SNAP_LVL  = 3'd2,
    OP_SNAP_END  = 3'd3,
    OP_TRADE     = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LVL_FULL = 2'd1,
    ST_Q_FULL  = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  localparam logic SIDE_BID = 1'b0;

  typedef struct packed {
    logic [2:0]         opcode;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   quantity;
    logic               end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [PRICE_W-1:0] best_bid_price;
    logic [QTY_W-1:0]   best_bid_qty;
    logic [PRICE_W-1:0] best_ask_price;
    logic [QTY_W-1:0]   best_ask_qty;
    logic [PRICE_W-1:0] last_trade_price;
    logic [QTY_W-1:0]   last_trade_qty;
    logic               quote_changed;
    logic               book_ready;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_WRITE,
    S_REPLAY_RD,
    S_REPLAY_GO,
    S_QUOTE_RD,
    S_QUOTE,
    S_OUT
  } state_t;

endpackage

[hw/rtl/order_book_top_of_book_core.sv]
`timescale 1ns / 1ps
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_ready  | in_item  (obtob_pkg::in_item_t)
// out     | out | out_valid/out_ready| out_item (obtob_pkg::out_item_t)
// one item at a time; in_ready is high only when the sequencer is idle.
// a level update scans the side table one entry a cycle through one comparator,
// then shifts entries one at a time, each through S_SHIFT_RD and S_SHIFT_WR;
// snapshot end replays the queue through the same unit.
// reset (rst, synchronous) clears counts, flags, quote and trade; no clearing pass.
// the result waits in an output register; the next item is taken once it is gone.
module order_book_top_of_book_core #(
  parameter int unsigned LEVEL_DEPTH   = 256,
  parameter int unsigned PENDING_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  obtob_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output obtob_pkg::out_item_t out_item
);
  import obtob_pkg::*;

  localparam int unsigned LA = $clog2(LEVEL_DEPTH);
  localparam int unsigned LC = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned PA = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int unsigned PC = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned EW = PRICE_W + QTY_W;
  localparam int unsigned QW = EW + 1;

  state_t state, state_next;

  logic [LC-1:0] bid_count, ask_count;
  logic [PC-1:0] pend_count;
  logic          book_rdy;
  logic [PRICE_W-1:0] q_bp, q_ap, t_p;
  logic [QTY_W-1:0]   q_bq, q_aq, t_q;

  // working operation
  logic               w_side, w_eom, w_replay, w_full_seen;
  logic [PRICE_W-1:0] w_price;
  logic [QTY_W-1:0]   w_qty;
  logic [LC-1:0]      idx, n_work, shift_k;
  logic [PC-1:0]      rp_idx;
  logic [1:0]         st;
  logic               chg;
  out_item_t          out_reg;
  logic               out_v;

  // write-phase decision
  logic       st_wr_en;
  logic [1:0] mode; // 0 write at idx, 1 insert shift, 2 erase shift
  logic       lv_we;
  status_t    acc_st;

  // level rams, one per side
  logic          bid_we, ask_we;
  logic [LA-1:0] lv_waddr, lv_raddr;
  logic [EW-1:0] lv_wdata, bid_rd, ask_rd, lv_rd;

  obtob_ram #(.WIDTH(EW), .DEPTH(LEVEL_DEPTH)) u_bid (
    .clk(clk), .we(bid_we), .waddr(lv_waddr), .wdata(lv_wdata),
    .raddr(lv_raddr), .rdata(bid_rd));
  obtob_ram #(.WIDTH(EW), .DEPTH(LEVEL_DEPTH)) u_ask (
    .clk(clk), .we(ask_we), .waddr(lv_waddr), .wdata(lv_wdata),
    .raddr(lv_raddr), .rdata(ask_rd));

  logic          pq_we;
  logic [PA-1:0] pq_waddr, pq_raddr;
  logic [QW-1:0] pq_wdata, pq_rd;

  obtob_ram #(.WIDTH(QW), .DEPTH(PENDING_DEPTH)) u_pend (
    .clk(clk), .we(pq_we), .waddr(pq_waddr), .wdata(pq_wdata),
    .raddr(pq_raddr), .rdata(pq_rd));

  assign lv_rd = w_side ? ask_rd : bid_rd;
  logic [PRICE_W-1:0] rd_price;
  assign rd_price = lv_rd[EW-1:QTY_W];

  // shared comparator: entry still ahead of the new price
  logic ahead, hit;
  assign ahead = w_side ? (rd_price < w_price) : (rd_price > w_price);
  assign hit   = (rd_price == w_price);

  logic idx_in, idx_nx_in, lvl_full;
  assign idx_in    = idx < n_work;
  assign idx_nx_in = (idx + LC'(1)) < n_work;
  assign lvl_full  = n_work >= LC'(LEVEL_DEPTH);

  // top of each table, empty sides read as the quiet quote
  logic [PRICE_W-1:0] qc_bp, qc_ap;
  logic [QTY_W-1:0]   qc_bq, qc_aq;
  assign qc_bp = (bid_count != '0) ? bid_rd[EW-1:QTY_W] : '0;
  assign qc_bq = (bid_count != '0) ? bid_rd[QTY_W-1:0] : '0;
  assign qc_ap = (ask_count != '0) ? ask_rd[EW-1:QTY_W] : '1;
  assign qc_aq = (ask_count != '0) ? ask_rd[QTY_W-1:0] : '0;

  assign in_ready  = (state == S_IDLE) && !out_v;
  assign out_valid = out_v;
  assign out_item  = out_reg;

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  assign st_wr_en = (mode == 2'd0);

  // finish of one level op: where to go next
  function automatic state_t after_level(input logic replay, input logic eom);
    if (replay) return S_REPLAY_RD;
    if (eom)    return S_QUOTE_RD;
    return S_OUT;
  endfunction

  // status known at the moment an item is taken
  always_comb begin
    acc_st = ST_OK;
    unique case (in_item.opcode)
      OP_LEVEL: begin
        if (!book_rdy && pend_count >= PC'(PENDING_DEPTH)) acc_st = ST_Q_FULL;
      end
      OP_SNAP_BEG, OP_SNAP_LVL, OP_SNAP_END: begin
        if (book_rdy) acc_st = ST_IGNORED;
      end
      OP_TRADE: acc_st = ST_OK;
      default:  acc_st = ST_IGNORED;
    endcase
  end

  // combinational sequencer controls
  always_comb begin
    state_next = state;
    lv_we      = 1'b0;
    lv_waddr   = idx[LA-1:0];
    lv_wdata   = {w_price, w_qty};
    lv_raddr   = idx[LA-1:0];
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_item.opcode)
            OP_LEVEL:    state_next = book_rdy ? S_SEARCH : S_OUT;
            OP_SNAP_LVL: state_next = book_rdy ? S_OUT : S_SEARCH;
            OP_SNAP_END: state_next = book_rdy ? S_OUT : S_REPLAY_RD;
            default:     state_next = S_OUT;
          endcase
        end
      end
      S_REPLAY_RD: state_next = (rp_idx >= pend_count) ? S_OUT : S_REPLAY_GO;
      S_REPLAY_GO: state_next = S_SEARCH;
      S_SEARCH: begin
        if (idx_in) state_next = S_DECIDE;
        else if (w_qty == '0 || lvl_full) state_next = after_level(w_replay, w_eom);
        else state_next = S_WRITE;
      end
      S_DECIDE: begin
        if (ahead) begin
          lv_raddr   = LA'(idx + LC'(1));
          state_next = idx_nx_in ? S_DECIDE : S_SEARCH;
        end else if (hit) begin
          state_next = (w_qty == '0) ? S_SHIFT_RD : S_WRITE;
        end else if (w_qty == '0 || lvl_full) begin
          state_next = after_level(w_replay, w_eom);
        end else begin
          state_next = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        lv_raddr = shift_k[LA-1:0];
        if (mode == 2'd1) state_next = S_SHIFT_WR;
        else if (shift_k >= n_work) state_next = after_level(w_replay, w_eom);
        else state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        // insert moves k to k+1 downward; erase moves k to k-1 upward
        lv_we    = 1'b1;
        lv_wdata = lv_rd;
        if (mode == 2'd1) begin
          lv_waddr   = LA'(shift_k + LC'(1));
          state_next = (shift_k == idx) ? S_WRITE : S_SHIFT_RD;
        end else begin
          lv_waddr   = LA'(shift_k - LC'(1));
          state_next = S_SHIFT_RD;
        end
      end
      S_WRITE: begin
        lv_we      = st_wr_en;
        state_next = after_level(w_replay, w_eom);
      end
      S_QUOTE_RD: begin
        lv_raddr   = '0;
        state_next = S_QUOTE;
      end
      S_QUOTE: state_next = S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign bid_we = lv_we && !w_side;
  assign ask_we = lv_we && w_side;

  assign pq_we    = in_fire && in_item.opcode == OP_LEVEL && !book_rdy &&
                    pend_count < PC'(PENDING_DEPTH);
  assign pq_waddr = pend_count[PA-1:0];
  assign pq_wdata = {in_item.side, in_item.price, in_item.quantity};
  assign pq_raddr = rp_idx[PA-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bid_count  <= '0;
      ask_count  <= '0;
      pend_count <= '0;
      book_rdy   <= 1'b0;
      q_bp <= '0; q_bq <= '0; q_ap <= '1; q_aq <= '0;
      t_p  <= '0; t_q  <= '0;
      out_v <= 1'b0;
    end else begin
      if (state == S_OUT) out_v <= 1'b1;
      else if (out_ready) out_v <= 1'b0;
      unique case (state)
        S_IDLE: if (in_fire) begin
          w_side   <= in_item.side;
          w_price  <= in_item.price;
          w_qty    <= in_item.quantity;
          // only live level changes close a message
          w_eom    <= (in_item.opcode == OP_LEVEL) && in_item.end_of_message;
          w_replay <= (in_item.opcode == OP_SNAP_END) && !book_rdy;
          w_full_seen <= 1'b0;
          chg      <= 1'b0;
          st       <= acc_st;
          idx      <= '0;
          n_work   <= in_item.side ? ask_count : bid_count;
          unique case (in_item.opcode)
            OP_LEVEL: begin
              if (!book_rdy && pend_count < PC'(PENDING_DEPTH))
                pend_count <= pend_count + PC'(1);
            end
            OP_SNAP_BEG: begin
              if (!book_rdy) begin bid_count <= '0; ask_count <= '0; end
            end
            OP_SNAP_END: rp_idx <= '0;
            OP_TRADE: begin
              t_p <= in_item.price; t_q <= in_item.quantity;
            end
            default: ;
          endcase
        end
        S_REPLAY_RD: begin
          if (rp_idx >= pend_count) begin
            pend_count <= '0;
            book_rdy   <= 1'b1;
            if (w_full_seen) st <= ST_LVL_FULL;
          end
        end
        S_REPLAY_GO: begin
          w_side  <= pq_rd[QW-1];
          w_price <= pq_rd[EW-1:QTY_W];
          w_qty   <= pq_rd[QTY_W-1:0];
          n_work  <= pq_rd[QW-1] ? ask_count : bid_count;
          idx     <= '0;
          rp_idx  <= rp_idx + PC'(1);
        end
        S_SEARCH: begin
          // append at end
          if (!idx_in && w_qty != '0) begin
            if (lvl_full) begin
              if (w_replay) w_full_seen <= 1'b1; else st <= ST_LVL_FULL;
            end else begin
              mode <= 2'd0;
              if (w_side) ask_count <= n_work + LC'(1);
              else bid_count <= n_work + LC'(1);
            end
          end
        end
        S_DECIDE: begin
          if (ahead) begin
            idx <= idx + LC'(1);
          end else if (hit) begin
            if (w_qty == '0) begin
              mode <= 2'd2; shift_k <= idx + LC'(1);
              if (w_side) ask_count <= n_work - LC'(1);
              else bid_count <= n_work - LC'(1);
            end else begin
              mode <= 2'd0;
            end
          end else if (w_qty != '0) begin
            if (lvl_full) begin
              if (w_replay) w_full_seen <= 1'b1; else st <= ST_LVL_FULL;
            end else begin
              mode <= 2'd1; shift_k <= n_work - LC'(1);
              if (w_side) ask_count <= n_work + LC'(1);
              else bid_count <= n_work + LC'(1);
            end
          end
        end
        S_SHIFT_WR: begin
          if (mode == 2'd1) begin
            if (shift_k == idx) mode <= 2'd0;
            else shift_k <= shift_k - LC'(1);
          end else begin
            shift_k <= shift_k + LC'(1);
          end
        end
        S_QUOTE: begin
          chg  <= (qc_bp != q_bp) || (qc_bq != q_bq) || (qc_ap != q_ap) || (qc_aq != q_aq);
          q_bp <= qc_bp; q_bq <= qc_bq; q_ap <= qc_ap; q_aq <= qc_aq;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_reg.best_bid_price   = q_bp;
    out_reg.best_bid_qty     = q_bq;
    out_reg.best_ask_price   = q_ap;
    out_reg.best_ask_qty     = q_aq;
    out_reg.last_trade_price = t_p;
    out_reg.last_trade_qty   = t_q;
    out_reg.quote_changed    = chg;
    out_reg.book_ready       = book_rdy;
    out_reg.status           = st;
  end

  assert property (@(posedge clk) disable iff (rst) out_v |-> !in_ready)
    else $error("input taken while a result waits");
  assert property (@(posedge clk) disable iff (rst)
    bid_count <= LC'(LEVEL_DEPTH) && ask_count <= LC'(LEVEL_DEPTH))
    else $error("level count overflow");
  assert property (@(posedge clk) disable iff (rst) $fell(book_rdy) |-> 1'b0)
    else $error("book ready dropped");
endmodule

[hw/rtl/obtob_ram.sv]
`timescale 1ns / 1ps
module obtob_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
